FILE: hw/rtl/prd_pkg.sv
// Shared types and constants of the priority request dispatcher.
package prd_pkg;

  localparam int PRIORITY_LEVELS_DEF = 5;
  localparam int QUEUE_DEPTH_DEF     = 64;
  localparam int MAX_ACTIVE_DEF      = 16;

  localparam int ID_W    = 16;
  localparam int KEY_W   = 32;
  localparam int LEVEL_W = 3;
  localparam int CODE_W  = 3;
  localparam int ACNT_W  = 5;
  localparam int WCNT_W  = 7;
  localparam int CFG_W   = 7;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_FINISH  = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [CODE_W-1:0] {
    EV_QUEUED    = 3'd0,
    EV_OVERFLOW  = 3'd1,
    EV_DUPLICATE = 3'd2,
    EV_STARTED   = 3'd3,
    EV_CANCELLED = 3'd4,
    EV_FINISHED  = 3'd5,
    EV_NOT_FOUND = 3'd6,
    EV_CLEARED   = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    CFG_MAX_CONCURRENT = 2'd0,
    CFG_ADAPTIVE_MODE  = 2'd1,
    CFG_CORE_COUNT     = 2'd2,
    CFG_QUEUE_CAPACITY = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DUP_RD,
    S_DUP_CMP,
    S_ENQ_WR,
    S_ST_RD,
    S_ST_CMP,
    S_SH_RD,
    S_SH_WR,
    S_SH_DONE,
    S_CAN_RD,
    S_CAN_CMP
  } state_t;

  typedef struct packed {
    opcode_t              op;
    logic [ID_W-1:0]      id;
    logic [KEY_W-1:0]     key;
    logic [LEVEL_W-1:0]   lv;
  } item_t;

  typedef struct packed {
    event_t               code;
    logic [ID_W-1:0]      id;
    logic [ACNT_W-1:0]    active;
    logic [WCNT_W-1:0]    waiting;
    logic                 last;
  } result_t;

endpackage

FILE: hw/rtl/priority_request_dispatcher.sv
// Top level of the strict-priority request dispatcher.
//
// Request transactions enter on req_valid / req_stall with opcode, request_id,
// request_key and priority_level; a transaction is taken at a clock edge where
// req_valid is high and req_stall is low. Event transactions leave on
// evt_valid / evt_stall, one or two per request; last_result marks the final one.
// A two-entry queue in the front end absorbs requests while the back end works,
// and the back end holds each event in an output register until it is taken.
// Work depends on the scans over the waiting store, which has one read port:
// an opcode resolved from the active table needs no scan, an enqueue scans the
// waiting requests for a duplicate, and a start or a waiting cancel adds the
// search and the compaction of the store. The back end takes no new request
// until it has finished the last one. When the receiver stalls, the back end
// waits with its event held, and the front end keeps taking requests until its
// queue is full. Reset empties the queues, clears the active table and loads
// the register defaults.
module priority_request_dispatcher #(
  parameter int PRIORITY_LEVELS = prd_pkg::PRIORITY_LEVELS_DEF,
  parameter int QUEUE_DEPTH     = prd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_ACTIVE      = prd_pkg::MAX_ACTIVE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [prd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  opcode,
  input  logic [prd_pkg::ID_W-1:0]    request_id,
  input  logic [prd_pkg::KEY_W-1:0]   request_key,
  input  logic [prd_pkg::LEVEL_W-1:0] priority_level,
  output logic                        evt_valid,
  input  logic                        evt_stall,
  output logic [prd_pkg::CODE_W-1:0]  event_code,
  output logic [prd_pkg::ID_W-1:0]    event_id,
  output logic [prd_pkg::ACNT_W-1:0]  active_count,
  output logic [prd_pkg::WCNT_W-1:0]  waiting_count,
  output logic                        last_result
);
  import prd_pkg::*;

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AAW = $clog2(MAX_ACTIVE + 1);

  // Configuration registers.
  logic [4:0] max_concurrent;
  logic       adaptive_mode;
  logic [3:0] core_count;
  logic [6:0] queue_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_concurrent <= 5'd4;
      adaptive_mode  <= 1'b0;
      core_count     <= 4'd4;
      queue_capacity <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_CONCURRENT: max_concurrent <= cfg_data[4:0];
        CFG_ADAPTIVE_MODE:  adaptive_mode  <= cfg_data[0];
        CFG_CORE_COUNT:     core_count     <= cfg_data[3:0];
        CFG_QUEUE_CAPACITY: queue_capacity <= cfg_data[6:0];
      endcase
    end
  end

  // The active limit follows the registers: adaptive cap of twice a nonzero core
  // count, then a floor of two and a ceiling of the active table size.
  logic [5:0]     lim_raw;
  logic [5:0]     twice_cores;
  logic [AAW-1:0] limit;
  logic [CW-1:0]  cap;

  assign twice_cores = {1'b0, core_count, 1'b0};

  always_comb begin
    lim_raw = {1'b0, max_concurrent};
    if (adaptive_mode && core_count != 4'd0 && lim_raw > twice_cores) begin
      lim_raw = twice_cores;
    end
    if (lim_raw < 6'd2) begin
      lim_raw = 6'd2;
    end
    if (32'(lim_raw) > MAX_ACTIVE) begin
      limit = AAW'(MAX_ACTIVE);
    end else begin
      limit = AAW'(lim_raw);
    end
    if (32'(queue_capacity) > QUEUE_DEPTH) begin
      cap = CW'(QUEUE_DEPTH);
    end else begin
      cap = CW'(queue_capacity);
    end
  end

  logic    item_valid;
  item_t   item;
  logic    item_pop;
  result_t evt;

  prd_front #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .request_id    (request_id),
    .request_key   (request_key),
    .priority_level(priority_level),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  prd_engine #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_ACTIVE     (MAX_ACTIVE)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_pop  (item_pop),
    .cap       (cap),
    .limit     (limit),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  assign event_code    = evt.code;
  assign event_id      = evt.id;
  assign active_count  = evt.active;
  assign waiting_count = evt.waiting;
  assign last_result   = evt.last;

endmodule

FILE: hw/rtl/prd_front.sv
// Front end: accepts request transactions, saturates the level, buffers them.
module prd_front #(
  parameter int PRIORITY_LEVELS = prd_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  opcode,
  input  logic [prd_pkg::ID_W-1:0]    request_id,
  input  logic [prd_pkg::KEY_W-1:0]   request_key,
  input  logic [prd_pkg::LEVEL_W-1:0] priority_level,
  output logic                        item_valid,
  output prd_pkg::item_t              item,
  input  logic                        item_pop
);
  import prd_pkg::*;

  item_t       q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        push;
  item_t       cls;

  assign req_stall  = (cnt == 2'd2);
  assign push       = req_valid && !req_stall;
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];

  always_comb begin
    cls.op  = opcode_t'(opcode);
    cls.id  = request_id;
    cls.key = request_key;
    if (32'(priority_level) >= PRIORITY_LEVELS) begin
      cls.lv = LEVEL_W'(PRIORITY_LEVELS - 1);
    end else begin
      cls.lv = priority_level;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (item_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(item_pop);
    end
  end

endmodule

FILE: hw/rtl/prd_engine.sv
// Back end: waiting store, level counts, active table and result register.
module prd_engine #(
  parameter int PRIORITY_LEVELS = prd_pkg::PRIORITY_LEVELS_DEF,
  parameter int QUEUE_DEPTH     = prd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_ACTIVE      = prd_pkg::MAX_ACTIVE_DEF,
  localparam int CW  = $clog2(QUEUE_DEPTH + 1),
  localparam int AAW = $clog2(MAX_ACTIVE + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  prd_pkg::item_t     item,
  output logic               item_pop,
  input  logic [CW-1:0]      cap,
  input  logic [AAW-1:0]     limit,
  output logic               evt_valid,
  input  logic               evt_stall,
  output prd_pkg::result_t   evt
);
  import prd_pkg::*;

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int LW  = $clog2(PRIORITY_LEVELS);
  localparam int MIW = $clog2(MAX_ACTIVE);
  localparam int EW  = KEY_W + ID_W + LW;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [LW-1:0]    lv;
  } entry_t;

  // Waiting store, kept in arrival order.
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= entry_t'(mem[mem_raddr]);
  end

  state_t         state, state_next;
  item_t          cur, cur_next;
  logic [CW-1:0]  p, p_next;
  logic [CW-1:0]  wtotal, wtotal_next;
  logic [CW-1:0]  lvl_cnt [PRIORITY_LEVELS];
  logic [CW-1:0]  lvl_cnt_next [PRIORITY_LEVELS];
  logic           act_valid [MAX_ACTIVE];
  logic           act_valid_next [MAX_ACTIVE];
  logic [ID_W-1:0] act_id [MAX_ACTIVE];
  logic [ID_W-1:0] act_id_next [MAX_ACTIVE];
  logic [AAW-1:0] atotal, atotal_next;
  logic           found, found_next;
  logic [LW-1:0]  best_lv, best_lv_next;
  logic [AW-1:0]  best_pos, best_pos_next;
  logic [LW-1:0]  rm_lv, rm_lv_next;
  logic           rm_start, rm_start_next;
  logic [ID_W-1:0] st_id, st_id_next;
  logic           evt_valid_next;
  result_t        evt_next;

  logic           out_free;
  logic           cur_hit;
  logic [MIW-1:0] cur_idx;
  logic           st_hit;
  logic           free_ok;
  logic [MIW-1:0] free_idx;
  logic [LW-1:0]  top_lv;
  logic [LW-1:0]  cur_lv;
  logic [AAW-1:0] a_dec;
  logic [AAW-1:0] a_inc;
  logic [CW-1:0]  w_dec;
  logic [CW-1:0]  w_inc;

  assign out_free = !evt_valid || !evt_stall;
  assign cur_lv   = LW'(cur.lv);
  assign a_dec    = atotal - AAW'(1);
  assign a_inc    = atotal + AAW'(1);
  assign w_dec    = wtotal - CW'(1);
  assign w_inc    = wtotal + CW'(1);

  // Table lookups over independent entries; the lowest index wins.
  always_comb begin
    cur_hit  = 1'b0;
    cur_idx  = '0;
    st_hit   = 1'b0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = MAX_ACTIVE - 1; i >= 0; i--) begin
      if (act_valid[i] && act_id[i] == cur.id) begin
        cur_hit = 1'b1;
        cur_idx = MIW'(i);
      end
      if (act_valid[i] && act_id[i] == st_id) begin
        st_hit = 1'b1;
      end
      if (!act_valid[i]) begin
        free_ok  = 1'b1;
        free_idx = MIW'(i);
      end
    end
  end

  always_comb begin
    top_lv = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (lvl_cnt[i] != '0) begin
        top_lv = LW'(i);
      end
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    p_next         = p;
    wtotal_next    = wtotal;
    lvl_cnt_next   = lvl_cnt;
    act_valid_next = act_valid;
    act_id_next    = act_id;
    atotal_next    = atotal;
    found_next     = found;
    best_lv_next   = best_lv;
    best_pos_next  = best_pos;
    rm_lv_next     = rm_lv;
    rm_start_next  = rm_start;
    st_id_next     = st_id;
    evt_valid_next = evt_valid && evt_stall;
    evt_next       = evt;
    item_pop       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = p[AW-1:0];
    mem_wdata      = rdata;
    mem_raddr      = p[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cur_next   = item;
          item_pop   = 1'b1;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (cur.op)
          OP_ENQUEUE: begin
            if (wtotal >= cap) begin
              if (out_free) begin
                evt_valid_next = 1'b1;
                evt_next = '{EV_OVERFLOW, cur.id, ACNT_W'(atotal), WCNT_W'(wtotal), 1'b1};
                state_next = S_IDLE;
              end
            end else begin
              p_next     = '0;
              state_next = S_DUP_RD;
            end
          end
          OP_CLEAR: begin
            if (out_free) begin
              for (int i = 0; i < MAX_ACTIVE; i++) begin
                act_valid_next[i] = 1'b0;
              end
              for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                lvl_cnt_next[i] = '0;
              end
              atotal_next    = '0;
              wtotal_next    = '0;
              evt_valid_next = 1'b1;
              evt_next       = '{EV_CLEARED, '0, '0, '0, 1'b1};
              state_next     = S_IDLE;
            end
          end
          default: begin
            if (cur_hit) begin
              if (out_free) begin
                act_valid_next[cur_idx] = 1'b0;
                atotal_next    = a_dec;
                evt_valid_next = 1'b1;
                evt_next.code  = (cur.op == OP_CANCEL) ? EV_CANCELLED : EV_FINISHED;
                evt_next.id      = cur.id;
                evt_next.active  = ACNT_W'(a_dec);
                evt_next.waiting = WCNT_W'(wtotal);
                evt_next.last    = !(a_dec < limit && wtotal != '0);
                p_next           = '0;
                state_next       = evt_next.last ? S_IDLE : S_ST_RD;
              end
            end else if (cur.op == OP_CANCEL) begin
              p_next     = '0;
              found_next = 1'b0;
              state_next = S_CAN_RD;
            end else if (out_free) begin
              evt_valid_next = 1'b1;
              evt_next = '{EV_NOT_FOUND, cur.id, ACNT_W'(atotal), WCNT_W'(wtotal), 1'b1};
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_DUP_RD: begin
        state_next = (p < wtotal) ? S_DUP_CMP : S_ENQ_WR;
      end

      S_DUP_CMP: begin
        if (rdata.lv == cur_lv && rdata.key == cur.key) begin
          if (out_free) begin
            evt_valid_next = 1'b1;
            evt_next = '{EV_DUPLICATE, cur.id, ACNT_W'(atotal), WCNT_W'(wtotal), 1'b1};
            state_next = S_IDLE;
          end
        end else begin
          p_next     = p + CW'(1);
          state_next = S_DUP_RD;
        end
      end

      S_ENQ_WR: begin
        if (out_free) begin
          mem_we                = 1'b1;
          mem_waddr             = wtotal[AW-1:0];
          mem_wdata             = {cur.key, cur.id, cur_lv};
          wtotal_next           = w_inc;
          lvl_cnt_next[cur_lv]  = lvl_cnt[cur_lv] + CW'(1);
          evt_valid_next        = 1'b1;
          evt_next.code         = EV_QUEUED;
          evt_next.id           = cur.id;
          evt_next.active       = ACNT_W'(atotal);
          evt_next.waiting      = WCNT_W'(w_inc);
          evt_next.last         = !(atotal < limit);
          p_next                = '0;
          state_next            = evt_next.last ? S_IDLE : S_ST_RD;
        end
      end

      S_ST_RD: begin
        state_next = S_ST_CMP;
      end

      S_ST_CMP: begin
        if (rdata.lv == top_lv) begin
          st_id_next    = rdata.id;
          rm_lv_next    = top_lv;
          rm_start_next = 1'b1;
          state_next    = S_SH_RD;
        end else begin
          p_next     = p + CW'(1);
          state_next = S_ST_RD;
        end
      end

      // Close the gap left by the removed entry: S_SH_RD reads each entry, S_SH_WR writes it one place lower.
      S_SH_RD: begin
        mem_raddr = p[AW-1:0] + AW'(1);
        if ((CW + 1)'(p) + (CW + 1)'(1) < (CW + 1)'(wtotal)) begin
          state_next = S_SH_WR;
        end else begin
          state_next = S_SH_DONE;
        end
      end

      S_SH_WR: begin
        mem_we     = 1'b1;
        p_next     = p + CW'(1);
        state_next = S_SH_RD;
      end

      S_SH_DONE: begin
        if (out_free) begin
          wtotal_next = w_dec;
          if (lvl_cnt[rm_lv] != '0) begin
            lvl_cnt_next[rm_lv] = lvl_cnt[rm_lv] - CW'(1);
          end
          evt_valid_next   = 1'b1;
          evt_next.waiting = WCNT_W'(w_dec);
          evt_next.last    = 1'b1;
          if (rm_start) begin
            evt_next.code   = EV_STARTED;
            evt_next.id     = st_id;
            evt_next.active = ACNT_W'(atotal);
            if (!st_hit && free_ok) begin
              act_valid_next[free_idx] = 1'b1;
              act_id_next[free_idx]    = st_id;
              atotal_next              = a_inc;
              evt_next.active          = ACNT_W'(a_inc);
            end
          end else begin
            evt_next.code   = EV_CANCELLED;
            evt_next.id     = cur.id;
            evt_next.active = ACNT_W'(atotal);
          end
          state_next = S_IDLE;
        end
      end

      S_CAN_RD: begin
        if (p < wtotal) begin
          state_next = S_CAN_CMP;
        end else if (found) begin
          p_next        = CW'(best_pos);
          rm_lv_next    = best_lv;
          rm_start_next = 1'b0;
          state_next    = S_SH_RD;
        end else if (out_free) begin
          evt_valid_next = 1'b1;
          evt_next = '{EV_NOT_FOUND, cur.id, ACNT_W'(atotal), WCNT_W'(wtotal), 1'b1};
          state_next = S_IDLE;
        end
      end

      S_CAN_CMP: begin
        if (rdata.id == cur.id && (!found || rdata.lv < best_lv)) begin
          found_next    = 1'b1;
          best_lv_next  = rdata.lv;
          best_pos_next = p[AW-1:0];
        end
        p_next     = p + CW'(1);
        state_next = S_CAN_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    p        <= p_next;
    found    <= found_next;
    best_lv  <= best_lv_next;
    best_pos <= best_pos_next;
    rm_lv    <= rm_lv_next;
    rm_start <= rm_start_next;
    st_id    <= st_id_next;
    evt      <= evt_next;
    act_id   <= act_id_next;
    if (rst) begin
      state     <= S_IDLE;
      wtotal    <= '0;
      atotal    <= '0;
      evt_valid <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        lvl_cnt[i] <= '0;
      end
      for (int i = 0; i < MAX_ACTIVE; i++) begin
        act_valid[i] <= 1'b0;
      end
    end else begin
      state     <= state_next;
      wtotal    <= wtotal_next;
      atotal    <= atotal_next;
      evt_valid <= evt_valid_next;
      lvl_cnt   <= lvl_cnt_next;
      act_valid <= act_valid_next;
    end
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the strict-priority request dispatcher.
`timescale 1ns / 1ps

module tb;
  import prd_pkg::*;

  // The longest stretch a correct run spends with no transaction: the
  // settle time between phases, or one slow scan over a full waiting store
  // while the event side stalls.
  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_LEVELS = 5;
  localparam int N_SLOTS = 16;
  localparam int STORE_DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_MAX_CONCURRENT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  opcode_t opcode = OP_ENQUEUE;
  logic [ID_W-1:0] request_id = '0;
  logic [KEY_W-1:0] request_key = '0;
  logic [LEVEL_W-1:0] priority_level = '0;
  logic evt_valid;
  logic evt_stall = 1'b0;
  logic [CODE_W-1:0] event_code;
  logic [ID_W-1:0] event_id;
  logic [ACNT_W-1:0] active_count;
  logic [WCNT_W-1:0] waiting_count;
  logic last_result;

  priority_request_dispatcher u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .request_id(request_id),
    .request_key(request_key), .priority_level(priority_level),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .event_code(event_code), .event_id(event_id),
    .active_count(active_count), .waiting_count(waiting_count),
    .last_result(last_result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the dispatcher state. Waiting requests are held in
  // arrival order; the FIFO of each level is the subsequence with that level.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0] id;
    int unsigned lv;
  } waiter_t;

  waiter_t waiting_list[$];
  bit slot_busy[N_SLOTS];
  logic [ID_W-1:0] slot_id[N_SLOTS];
  int unsigned busy_total;
  int unsigned dispatch_limit;
  int unsigned reg_max_concurrent = 4;
  int unsigned reg_adaptive = 0;
  int unsigned reg_cores = 4;
  int unsigned reg_capacity = 64;

  result_t pending_events[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int requests_sent = 0;
  int events_seen = 0;
  int cfg_writes = 0;
  int code_hits[8];
  int quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic void update_limit();
    int unsigned m;
    m = reg_max_concurrent;
    if (reg_adaptive != 0 && reg_cores != 0 && m > 2 * reg_cores) m = 2 * reg_cores;
    if (m < 2) m = 2;
    if (m > N_SLOTS) m = N_SLOTS;
    dispatch_limit = m;
  endfunction

  function automatic void add_event(event_t code, logic [ID_W-1:0] id, bit last);
    result_t ev;
    ev.code = code;
    ev.id = id;
    ev.active = busy_total[ACNT_W-1:0];
    ev.waiting = WCNT_W'(waiting_list.size());
    ev.last = last;
    pending_events.push_back(ev);
  endfunction

  function automatic int find_busy(logic [ID_W-1:0] id);
    for (int i = 0; i < N_SLOTS; i++)
      if (slot_busy[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  // Start the oldest request of the highest non-empty level.
  function automatic void launch_next();
    int pos;
    int slot;
    logic [ID_W-1:0] id;
    pos = -1;
    for (int lv = N_LEVELS - 1; lv >= 0 && pos < 0; lv--)
      for (int p = 0; p < waiting_list.size(); p++)
        if (waiting_list[p].lv == lv) begin
          pos = p;
          break;
        end
    if (pos < 0) return;
    id = waiting_list[pos].id;
    waiting_list.delete(pos);
    slot = find_busy(id);
    if (slot < 0) begin
      for (int i = 0; i < N_SLOTS; i++)
        if (!slot_busy[i]) begin
          slot = i;
          break;
        end
      if (slot >= 0) begin
        slot_busy[slot] = 1'b1;
        slot_id[slot] = id;
        busy_total++;
      end
    end
    add_event(EV_STARTED, id, 1'b1);
  endfunction

  // Works out the events that one accepted request transaction causes.
  function automatic void predict_events(opcode_t op, logic [ID_W-1:0] id,
                                         logic [KEY_W-1:0] key,
                                         logic [LEVEL_W-1:0] lv_in);
    int unsigned lv;
    int unsigned cap;
    int slot;
    bit can_launch;
    waiter_t w;
    lv = (lv_in >= N_LEVELS) ? N_LEVELS - 1 : lv_in;
    cap = (reg_capacity > STORE_DEPTH) ? STORE_DEPTH : reg_capacity;
    case (op)
      OP_ENQUEUE: begin
        if (waiting_list.size() >= cap) begin
          add_event(EV_OVERFLOW, id, 1'b1);
          return;
        end
        foreach (waiting_list[p])
          if (waiting_list[p].lv == lv && waiting_list[p].key == key) begin
            add_event(EV_DUPLICATE, id, 1'b1);
            return;
          end
        w.key = key;
        w.id = id;
        w.lv = lv;
        waiting_list.push_back(w);
        can_launch = busy_total < dispatch_limit;
        add_event(EV_QUEUED, id, !can_launch);
        if (can_launch) launch_next();
      end
      OP_CLEAR: begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        busy_total = 0;
        waiting_list.delete();
        add_event(EV_CLEARED, '0, 1'b1);
      end
      default: begin
        slot = find_busy(id);
        if (slot >= 0) begin
          slot_busy[slot] = 1'b0;
          busy_total--;
          can_launch = busy_total < dispatch_limit && waiting_list.size() != 0;
          add_event(op == OP_CANCEL ? EV_CANCELLED : EV_FINISHED, id, !can_launch);
          if (can_launch) launch_next();
          return;
        end
        if (op == OP_CANCEL)
          for (int l = 0; l < N_LEVELS; l++)
            for (int p = 0; p < waiting_list.size(); p++)
              if (waiting_list[p].lv == l && waiting_list[p].id == id) begin
                waiting_list.delete(p);
                add_event(EV_CANCELLED, id, 1'b1);
                return;
              end
        add_event(EV_NOT_FOUND, id, 1'b1);
      end
    endcase
  endfunction

  // Drives one request transaction at the falling edge and holds it until
  // the dispatcher takes it; the sender may idle first.
  task automatic send_request(opcode_t op, logic [ID_W-1:0] id,
                              logic [KEY_W-1:0] key, logic [LEVEL_W-1:0] lv);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    request_id <= id;
    request_key <= key;
    priority_level <= lv;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_events(op, id, key, lv);
    requests_sent++;
  endtask

  // Lowers valid, waits for every expected event and then lets the block
  // finish any work that produces no further event.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_CONCURRENT: reg_max_concurrent = value & 31;
      CFG_ADAPTIVE_MODE: reg_adaptive = value & 1;
      CFG_CORE_COUNT: reg_cores = value & 15;
      default: reg_capacity = value & 127;
    endcase
    update_limit();
    cfg_writes++;
  endtask

  // Event side: stalls at random and checks each accepted event against
  // the oldest expectation.
  always @(negedge clk) begin
    evt_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && evt_valid && !evt_stall) begin
      events_seen++;
      code_hits[event_code]++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event code %0d id %0h", event_code, event_id));
      end else begin
        want = pending_events.pop_front();
        if (event_code != want.code)
          report_mismatch($sformatf("event_code %0d, expected %0d", event_code, want.code));
        if (event_id != want.id)
          report_mismatch($sformatf("event_id %0h, expected %0h", event_id, want.id));
        if (active_count != want.active)
          report_mismatch($sformatf("active_count %0d, expected %0d",
                                    active_count, want.active));
        if (waiting_count != want.waiting)
          report_mismatch($sformatf("waiting_count %0d, expected %0d",
                                    waiting_count, want.waiting));
        if (last_result != want.last)
          report_mismatch($sformatf("last_result %0b, expected %0b", last_result, want.last));
      end
    end
  end

  // The watchdog counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (evt_valid && !evt_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: timeout with %0d events outstanding", pending_events.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hand-picked requests that walk through every opcode and the corner cases:
  // level saturation, duplicate keys, the same id waiting twice, cancel of a
  // waiting request from the lowest level, restart of an id that is active.
  task automatic test_directed_requests();
    send_request(OP_ENQUEUE, 16'h0001, 32'h0000_00AA, 3'd0);
    send_request(OP_ENQUEUE, 16'h0002, 32'h0000_00AA, 3'd7);
    send_request(OP_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 3'd4);
    send_request(OP_ENQUEUE, 16'h0000, 32'h0000_0000, 3'd4);
    send_request(OP_ENQUEUE, 16'h0005, 32'h0000_0010, 3'd2);
    send_request(OP_ENQUEUE, 16'h0006, 32'h0000_0010, 3'd2);
    send_request(OP_ENQUEUE, 16'h0005, 32'h0000_0011, 3'd1);
    send_request(OP_ENQUEUE, 16'h0007, 32'h0000_0010, 3'd5);
    send_request(OP_CANCEL, 16'h0005, 32'h0, 3'd0);
    send_request(OP_FINISH, 16'h0001, 32'h0, 3'd0);
    send_request(OP_FINISH, 16'h1234, 32'h0, 3'd0);
    send_request(OP_CANCEL, 16'h4321, 32'h0, 3'd0);
    send_request(OP_ENQUEUE, 16'h0002, 32'h0000_0020, 3'd3);
    send_request(OP_FINISH, 16'hFFFF, 32'h0, 3'd0);
    send_request(OP_CANCEL, 16'h0000, 32'h0, 3'd0);
    send_request(OP_ENQUEUE, 16'hAAAA, 32'h5555_5555, 3'd6);
    send_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
    send_request(OP_FINISH, 16'h0002, 32'h0, 3'd0);
  endtask

  // Drives each register to its extremes: zero capacity, a lowered limit
  // with requests still active, and the adaptive cap on and off.
  task automatic test_register_extremes();
    write_reg(CFG_QUEUE_CAPACITY, 0);
    send_request(OP_ENQUEUE, 16'h0100, 32'h1, 3'd1);
    write_reg(CFG_QUEUE_CAPACITY, 64);
    write_reg(CFG_MAX_CONCURRENT, 16);
    write_reg(CFG_ADAPTIVE_MODE, 1);
    write_reg(CFG_CORE_COUNT, 8);
    for (int i = 0; i < 5; i++)
      send_request(OP_ENQUEUE, ID_W'(16'h0200 + i), KEY_W'(32'h100 + i), LEVEL_W'(i));
    write_reg(CFG_MAX_CONCURRENT, 1);
    send_request(OP_ENQUEUE, 16'h0300, 32'h300, 3'd2);
    send_request(OP_FINISH, 16'h0200, 32'h0, 3'd0);
    write_reg(CFG_CORE_COUNT, 0);
    write_reg(CFG_ADAPTIVE_MODE, 0);
    send_request(OP_CLEAR, 16'h0, 32'h0, 3'd0);
  endtask

  function automatic logic [ID_W-1:0] random_id();
    return ($urandom_range(99) < 80) ? ID_W'($urandom_range(0, 255))
                                     : ID_W'($urandom_range(0, 65535));
  endfunction

  // Mostly well-formed traffic: finishes and cancels aim at ids that are
  // active or waiting, keys come from a small pool to hit duplicates.
  task automatic test_random_traffic(int count);
    opcode_t op;
    logic [ID_W-1:0] id;
    logic [KEY_W-1:0] key;
    int r;
    int slot;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      id = random_id();
      key = ($urandom_range(1) != 0) ? $urandom_range(0, 15) : $urandom;
      if (r < 55) begin
        op = OP_ENQUEUE;
      end else if (r < 97) begin
        op = (r < 77) ? OP_FINISH : OP_CANCEL;
        slot = $urandom_range(N_SLOTS - 1);
        if (op == OP_CANCEL && waiting_list.size() != 0 && $urandom_range(1) != 0)
          id = waiting_list[$urandom_range(waiting_list.size() - 1)].id;
        else if (busy_total != 0 && $urandom_range(99) < 85) begin
          while (!slot_busy[slot]) slot = (slot + 1) % N_SLOTS;
          id = slot_id[slot];
        end
      end else begin
        op = opcode_t'($urandom_range(3));
      end
      send_request(op, id, key, LEVEL_W'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    update_limit();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    stall_pct = 84;
    test_directed_requests();
    test_register_extremes();
    write_reg(CFG_MAX_CONCURRENT, 16);
    write_reg(CFG_ADAPTIVE_MODE, 1);
    write_reg(CFG_CORE_COUNT, 3);
    write_reg(CFG_QUEUE_CAPACITY, 12);
    test_random_traffic(530);

    drain();
    send_idle_pct = 84;
    stall_pct = 17;
    write_reg(CFG_MAX_CONCURRENT, 1);
    write_reg(CFG_ADAPTIVE_MODE, 0);
    write_reg(CFG_QUEUE_CAPACITY, 64);
    test_random_traffic(530);

    drain();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_MAX_CONCURRENT, 16);
    write_reg(CFG_ADAPTIVE_MODE, 1);
    write_reg(CFG_CORE_COUNT, 0);
    write_reg(CFG_QUEUE_CAPACITY, 30);
    test_random_traffic(530);

    drain();
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
    $display("tb: %0d requests, %0d events, %0d register writes", requests_sent,
             events_seen, cfg_writes);
    $display("tb: events by code: %0d %0d %0d %0d %0d %0d %0d %0d, %0d mismatches",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5], code_hits[6], code_hits[7], errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
